[rtl/bti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bti_pkg;

	localparam int DEF_MAX_COLUMNS = 16;
	localparam int DEF_MAX_ROWS    = 16;
	localparam int DEF_VALUE_BITS  = 16;

	localparam int FRAC_BITS = 16;
	localparam int KEY_BITS  = 16;
	localparam int DIV_BITS  = 2 * FRAC_BITS + 1;

	localparam logic [1:0] ACT_COL_BREAK = 2'd0;
	localparam logic [1:0] ACT_ROW_BREAK = 2'd1;
	localparam logic [1:0] ACT_GRID      = 2'd2;
	localparam logic [1:0] ACT_QUERY     = 2'd3;

	localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
	localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
	localparam logic [1:0] REG_UNITY_ZERO   = 2'd2;

	localparam logic [1:0] ST_INSIDE    = 2'd0;
	localparam logic [1:0] ST_CLAMPED   = 2'd1;
	localparam logic [1:0] ST_ZERO_SPAN = 2'd2;

	localparam logic [15:0] UNITY_Q14 = 16'd16384;

endpackage
`default_nettype wire

[rtl/bti_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module bti_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [bti_pkg::DIV_BITS-1:0]      num,
	input  wire logic [bti_pkg::KEY_BITS-1:0]      den,
	output logic                                   done,
	output logic [bti_pkg::FRAC_BITS:0]            quot
);
	import bti_pkg::*;

	localparam int CW = $clog2(DIV_BITS);

	logic [FRAC_BITS:0]   rem_q;
	logic [DIV_BITS-1:0]  num_q;
	logic [FRAC_BITS:0]   quot_q;
	logic [KEY_BITS-1:0]  den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [FRAC_BITS+1:0] trial;
	logic                 ge;

	assign trial = {rem_q, num_q[DIV_BITS-1]};
	assign ge    = trial >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			num_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (FRAC_BITS + 1)'(trial - {2'b00, den_q}) : (FRAC_BITS + 1)'(trial);
			num_q  <= {num_q[DIV_BITS-2:0], 1'b0};
			quot_q <= {quot_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

[rtl/bti_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module bti_mul #(
	parameter int VALUE_BITS = bti_pkg::DEF_VALUE_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic [VALUE_BITS-1:0]                 a,
	input  wire logic [bti_pkg::FRAC_BITS:0]           b,
	output logic [VALUE_BITS+bti_pkg::FRAC_BITS:0]     prod
);
	import bti_pkg::*;

	logic [VALUE_BITS+FRAC_BITS:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= (VALUE_BITS + FRAC_BITS + 1)'(a) * (VALUE_BITS + FRAC_BITS + 1)'(b);
		end
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

[rtl/bilinear_table_interpolator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Contents
// s         in         s_tvalid/s_tready  tuser: action; tdata: row_index, column_index,
//                                         write_value, column_key, row_key
// m         out        m_tvalid/m_tready  tdata: interpolated; tuser: status
// cfg       in         cfg_we             cfg_index selects the register, cfg_data the value
// A write request is stored when it is taken. A query scans each axis over its breakpoints,
// reading and then comparing each one, runs a 33-step restoring divider on each axis whose key
// lies between two breakpoints of nonzero span and then six read, multiply and accumulate steps;
// a clamped or zero-span axis skips the divider. With unity set, a zero row_key returns UNITY_Q14.
// The block takes no request while a query is in work or its result waits on m_tready.
// Reset clears the control state and unity and sets both counts to 16; tables are not cleared.
module bilinear_table_interpolator_unit #(
	parameter int MAX_COLUMNS = bti_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = bti_pkg::DEF_MAX_ROWS,
	parameter int VALUE_BITS  = bti_pkg::DEF_VALUE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // row_index, column_index, write_value, column_key, row_key
	input  wire logic [1:0]  s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // interpolated
	output logic [1:0]       m_tuser,  // status
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_data
);
	import bti_pkg::*;

	localparam int CIW = $clog2(MAX_COLUMNS);
	localparam int RIW = $clog2(MAX_ROWS);
	localparam int AXW = (CIW > RIW) ? CIW : RIW;
	localparam int GAW = $clog2(MAX_COLUMNS * MAX_ROWS);
	localparam int WB  = FRAC_BITS + 1;
	localparam int PW  = VALUE_BITS + WB;
	localparam int ACW = PW + 1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN_RD  = 4'd1;
	localparam logic [3:0] S_SCAN_USE = 4'd2;
	localparam logic [3:0] S_LOW_RD   = 4'd3;
	localparam logic [3:0] S_LOW_USE  = 4'd4;
	localparam logic [3:0] S_HIGH_RD  = 4'd5;
	localparam logic [3:0] S_HIGH_USE = 4'd6;
	localparam logic [3:0] S_DIV      = 4'd7;
	localparam logic [3:0] S_NEXT     = 4'd8;
	localparam logic [3:0] S_T_RD     = 4'd9;
	localparam logic [3:0] S_T_MUL    = 4'd10;
	localparam logic [3:0] S_T_ACC    = 4'd11;
	localparam logic [3:0] S_OUT      = 4'd12;

	logic [1:0]           action;
	logic [3:0]           row_index;
	logic [3:0]           column_index;
	logic [15:0]          write_value;
	logic [15:0]          column_key;
	logic [15:0]          row_key;

	logic [15:0]          col_mem [MAX_COLUMNS];
	logic [15:0]          row_mem [MAX_ROWS];
	logic [VALUE_BITS-1:0] grid_mem [MAX_COLUMNS * MAX_ROWS];
	logic [15:0]          col_rd_q, row_rd_q;
	logic [VALUE_BITS-1:0] grid_rd_q;

	logic [4:0]           col_cnt_q, row_cnt_q;
	logic                 unity_q;

	logic [3:0]           state_q;
	logic                 axis_q;
	logic [15:0]          ckey_q, rkey_q;
	logic [AXW-1:0]       k_q, cnt_q;
	logic [15:0]          first_q, low_q;
	logic [AXW-1:0]       lo_q, hi_q, c0_q, c1_q, r0_q, r1_q;
	logic [FRAC_BITS:0]   frac_q, wc_q, wr_q;
	logic [1:0]           st_q, sc_q, sr_q;
	logic [2:0]           t_q;
	logic [ACW-1:0]       acc_q;
	logic [VALUE_BITS-1:0] top_q, bot_q;
	logic [15:0]          out_data_q;
	logic [1:0]           out_stat_q;

	int                   nc_int, nr_int;
	logic [AXW-1:0]       last_idx, bp_addr;
	logic [15:0]          key, bp_rd, span, off;
	logic [AXW-1:0]       g_row, g_col;
	logic [GAW-1:0]       g_addr;
	logic [VALUE_BITS-1:0] mul_a;
	logic [FRAC_BITS:0]   w_sel, mul_b;
	logic [PW-1:0]        prod;
	logic [ACW-1:0]       acc_sum;
	logic                 div_start, div_done;
	logic [DIV_BITS-1:0]  div_num;
	logic [FRAC_BITS:0]   div_quot;
	logic                 s_acc;

	assign action       = s_tuser;
	assign row_index    = s_tdata[3:0];
	assign column_index = s_tdata[7:4];
	assign write_value  = s_tdata[23:8];
	assign column_key   = s_tdata[39:24];
	assign row_key      = s_tdata[55:40];

	assign s_tready = state_q == S_IDLE;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = state_q == S_OUT;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;

	always_comb begin
		if (col_cnt_q < 5'd2) nc_int = 2;
		else if (32'(col_cnt_q) > MAX_COLUMNS) nc_int = MAX_COLUMNS;
		else nc_int = 32'(col_cnt_q);
		if (row_cnt_q < 5'd2) nr_int = 2;
		else if (32'(row_cnt_q) > MAX_ROWS) nr_int = MAX_ROWS;
		else nr_int = 32'(row_cnt_q);
	end

	assign last_idx = axis_q ? AXW'(nr_int - 1) : AXW'(nc_int - 1);
	assign key      = axis_q ? rkey_q : ckey_q;
	assign bp_rd    = axis_q ? row_rd_q : col_rd_q;

	always_comb begin
		case (state_q)
			S_LOW_RD:  bp_addr = cnt_q;
			S_HIGH_RD: bp_addr = cnt_q + 1'b1;
			default:   bp_addr = k_q;
		endcase
	end

	assign span = bp_rd - low_q;
	always_comb begin
		off = (key > low_q) ? key - low_q : 16'd0;
		if (off > span) off = span;
	end
	assign div_num   = DIV_BITS'({off, 16'h0000}) + DIV_BITS'(span >> 1);
	assign div_start = (state_q == S_HIGH_USE) && (bp_rd > low_q);

	assign g_row  = t_q[1] ? r1_q : r0_q;
	assign g_col  = t_q[0] ? c1_q : c0_q;
	assign g_addr = GAW'(32'(g_row) * MAX_COLUMNS + 32'(g_col));

	always_comb begin
		if (t_q < 3'd4) mul_a = grid_rd_q;
		else if (t_q == 3'd4) mul_a = top_q;
		else mul_a = bot_q;
	end
	assign w_sel   = (t_q < 3'd4) ? wc_q : wr_q;
	assign mul_b   = t_q[0] ? w_sel : WB'(1 << FRAC_BITS) - w_sel;
	assign acc_sum = (t_q[0] ? acc_q : ACW'(1 << (FRAC_BITS - 1))) + ACW'(prod);

	bti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (span),
		.done   (div_done),
		.quot   (div_quot)
	);

	bti_mul #(.VALUE_BITS(VALUE_BITS)) u_mul (
		.clk  (clk),
		.en   (state_q == S_T_MUL),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk) begin
		if (s_acc && action == ACT_COL_BREAK && 32'(column_index) < MAX_COLUMNS) begin
			col_mem[CIW'(column_index)] <= write_value;
		end
		if (s_acc && action == ACT_ROW_BREAK && 32'(row_index) < MAX_ROWS) begin
			row_mem[RIW'(row_index)] <= write_value;
		end
		if (s_acc && action == ACT_GRID && 32'(row_index) < MAX_ROWS
				&& 32'(column_index) < MAX_COLUMNS) begin
			grid_mem[GAW'(32'(row_index) * MAX_COLUMNS + 32'(column_index))] <=
				VALUE_BITS'(write_value);
		end
		col_rd_q  <= col_mem[bp_addr[CIW-1:0]];
		row_rd_q  <= row_mem[bp_addr[RIW-1:0]];
		grid_rd_q <= grid_mem[g_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= 5'd16;
			row_cnt_q <= 5'd16;
			unity_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLUMN_COUNT: col_cnt_q <= cfg_data;
				REG_ROW_COUNT:    row_cnt_q <= cfg_data;
				REG_UNITY_ZERO:   unity_q   <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
			t_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_acc && action == ACT_QUERY) begin
						if (unity_q && row_key == 16'd0) begin
							state_q <= S_OUT;
						end else begin
							axis_q  <= 1'b0;
							k_q     <= '0;
							cnt_q   <= '0;
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_USE;
				S_SCAN_USE: begin
					if (k_q != '0 && k_q != last_idx && bp_rd <= key) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (k_q == last_idx) begin
						if (key < first_q || key > bp_rd) state_q <= S_NEXT;
						else state_q <= S_LOW_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_LOW_RD:  state_q <= S_LOW_USE;
				S_LOW_USE: state_q <= S_HIGH_RD;
				S_HIGH_RD: state_q <= S_HIGH_USE;
				S_HIGH_USE: state_q <= div_start ? S_DIV : S_NEXT;
				S_DIV: begin
					if (div_done) state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						k_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_SCAN_RD;
					end else begin
						t_q     <= '0;
						state_q <= S_T_RD;
					end
				end
				S_T_RD:  state_q <= S_T_MUL;
				S_T_MUL: state_q <= S_T_ACC;
				S_T_ACC: begin
					if (t_q == 3'd5) begin
						state_q <= S_OUT;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= S_T_RD;
					end
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ckey_q     <= column_key;
				rkey_q     <= row_key;
				out_data_q <= UNITY_Q14;
				out_stat_q <= ST_INSIDE;
			end
			S_SCAN_USE: begin
				if (k_q == '0) first_q <= bp_rd;
				if (k_q == last_idx) begin
					frac_q <= '0;
					st_q   <= ST_CLAMPED;
					if (key < first_q) begin
						lo_q <= '0;
						hi_q <= '0;
					end else begin
						lo_q <= last_idx;
						hi_q <= last_idx;
					end
				end
			end
			S_LOW_USE: begin
				low_q <= bp_rd;
				lo_q  <= cnt_q;
				hi_q  <= cnt_q + 1'b1;
			end
			S_HIGH_USE: begin
				frac_q <= '0;
				st_q   <= div_start ? ST_INSIDE : ST_ZERO_SPAN;
			end
			S_DIV: begin
				if (div_done) frac_q <= div_quot;
			end
			S_NEXT: begin
				if (!axis_q) begin
					c0_q <= lo_q;
					c1_q <= hi_q;
					wc_q <= frac_q;
					sc_q <= st_q;
				end else begin
					r0_q <= lo_q;
					r1_q <= hi_q;
					wr_q <= frac_q;
					sr_q <= st_q;
				end
			end
			S_T_ACC: begin
				acc_q <= acc_sum;
				if (t_q == 3'd1) top_q <= VALUE_BITS'(acc_sum >> FRAC_BITS);
				if (t_q == 3'd3) bot_q <= VALUE_BITS'(acc_sum >> FRAC_BITS);
				if (t_q == 3'd5) begin
					out_data_q <= 16'(VALUE_BITS'(acc_sum >> FRAC_BITS));
					if (sc_q == ST_ZERO_SPAN || sr_q == ST_ZERO_SPAN) out_stat_q <= ST_ZERO_SPAN;
					else if (sc_q == ST_CLAMPED || sr_q == ST_CLAMPED) out_stat_q <= ST_CLAMPED;
					else out_stat_q <= ST_INSIDE;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[dv/bilinear_table_interpolator_unit_tb.sv]
`timescale 1ns / 1ps
module bilinear_table_interpolator_unit_tb;
	import bti_pkg::*;

	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  status;
	} lookup_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  action;
		logic [3:0]  ri;
		logic [3:0]  ci;
		logic [15:0] wv;
		logic [15:0] ck;
		logic [15:0] rk;
		bit          fixed;
		lookup_t     fixed_exp;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	wire         s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	wire         m_tvalid;
	logic        m_tready;
	wire  [15:0] m_tdata;
	wire  [1:0]  m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [4:0]  cfg_data;

	logic [15:0] col_bp [16];
	logic [15:0] row_bp [16];
	logic [15:0] grid_val [256];
	logic [4:0]  col_count_reg;
	logic [4:0]  row_count_reg;
	logic        unity_reg;

	lookup_t pending_lookups [$];
	row_t    directed_rows [$];
	int      mismatches;
	int      lookups_checked;
	int      requests_sent;
	int      idle_pct;
	int      stall_pct;

	bilinear_table_interpolator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int clamp_count(input logic [4:0] r);
		if (r < 2) return 2;
		if (r > 16) return 16;
		return int'(r);
	endfunction

	function automatic logic [1:0] bracket(input bit on_cols, input logic [15:0] key,
			input int n, output int lo, output int hi, output logic [16:0] frac);
		logic [15:0] bp [16];
		int          i;
		logic [15:0] low;
		logic [15:0] up;
		logic [31:0] span;
		logic [31:0] off;
		longint unsigned q;
		for (int k = 0; k < 16; k++) bp[k] = on_cols ? col_bp[k] : row_bp[k];
		frac = '0;
		if (key < bp[0]) begin
			lo = 0;
			hi = 0;
			return ST_CLAMPED;
		end
		if (key > bp[n - 1]) begin
			lo = n - 1;
			hi = n - 1;
			return ST_CLAMPED;
		end
		i = 0;
		for (int k = 1; k + 1 < n; k++)
			if (bp[k] <= key) i++;
		low = bp[i];
		up = bp[i + 1];
		lo = i;
		hi = i + 1;
		if (up <= low) return ST_ZERO_SPAN;
		span = up - low;
		off = (key > low) ? key - low : 0;
		if (off > span) off = span;
		q = ((longint'(off) << 16) + (span >> 1)) / span;
		frac = q[16:0];
		return ST_INSIDE;
	endfunction

	function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
			input logic [16:0] w);
		longint unsigned s;
		s = longint'(a) * (65536 - w) + longint'(b) * w + 32768;
		return s[47:16];
	endfunction

	function automatic lookup_t interpolate(input logic [15:0] ck, input logic [15:0] rk);
		lookup_t     r;
		int          c0, c1, r0, r1;
		logic [16:0] wc, wr;
		logic [1:0]  sc, sr;
		logic [31:0] top, bot, res;
		if (unity_reg && rk == 0) begin
			r.value = UNITY_Q14;
			r.status = ST_INSIDE;
			return r;
		end
		sc = bracket(1'b1, ck, clamp_count(col_count_reg), c0, c1, wc);
		sr = bracket(1'b0, rk, clamp_count(row_count_reg), r0, r1, wr);
		top = mix(grid_val[r0 * 16 + c0], grid_val[r0 * 16 + c1], wc);
		bot = mix(grid_val[r1 * 16 + c0], grid_val[r1 * 16 + c1], wc);
		res = mix(top, bot, wr);
		r.value = res[15:0];
		if (sc == ST_ZERO_SPAN || sr == ST_ZERO_SPAN) r.status = ST_ZERO_SPAN;
		else if (sc == ST_CLAMPED || sr == ST_CLAMPED) r.status = ST_CLAMPED;
		else r.status = ST_INSIDE;
		return r;
	endfunction

	// Updates the table copy for a write, or queues the lookup a query should return.
	task automatic apply_request(input logic [1:0] act, input logic [3:0] ri,
			input logic [3:0] ci, input logic [15:0] wv, input logic [15:0] ck,
			input logic [15:0] rk, input bit fixed, input lookup_t fixed_exp);
		lookup_t item;
		case (act)
			ACT_COL_BREAK: col_bp[ci] = wv;
			ACT_ROW_BREAK: row_bp[ri] = wv;
			ACT_GRID: grid_val[ri * 16 + ci] = wv;
			default: begin
				item = fixed ? fixed_exp : interpolate(ck, rk);
				pending_lookups.insert(pending_lookups.size(), item);
			end
		endcase
	endtask

	task automatic send(input logic [1:0] act, input logic [3:0] ri, input logic [3:0] ci,
			input logic [15:0] wv, input logic [15:0] ck, input logic [15:0] rk,
			input bit fixed = 1'b0, input lookup_t fixed_exp = '0);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {rk, ck, wv, ci, ri};
		do @(posedge clk); while (!s_tready);
		apply_request(act, ri, ci, wv, ck, rk, fixed, fixed_exp);
		requests_sent++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COLUMN_COUNT: col_count_reg = val;
			REG_ROW_COUNT: row_count_reg = val;
			REG_UNITY_ZERO: unity_reg = val[0];
			default: ;
		endcase
	endtask

	task automatic add_row(input bit is_cfg, input logic [1:0] act, input logic [3:0] ri,
			input logic [3:0] ci, input logic [15:0] wv, input logic [15:0] ck,
			input logic [15:0] rk, input bit fixed = 1'b0, input lookup_t fe = '0);
		row_t r;
		r.is_cfg = is_cfg;
		r.action = act;
		r.ri = ri;
		r.ci = ci;
		r.wv = wv;
		r.ck = ck;
		r.rk = rk;
		r.fixed = fixed;
		r.fixed_exp = fe;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	function automatic logic [15:0] pick_between(input logic [15:0] lo, input logic [15:0] hi);
		if ($urandom_range(9) == 0) return 16'($urandom);
		if ($urandom_range(19) == 0) return lo;
		if (lo > hi) return lo;
		return 16'($urandom_range(hi, lo));
	endfunction

	function automatic logic [15:0] pick_key(input bit on_cols);
		int n;
		n = clamp_count(on_cols ? col_count_reg : row_count_reg);
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return on_cols ? col_bp[$urandom_range(n - 1)] : row_bp[$urandom_range(n - 1)];
			4: return 16'($urandom);
			default: begin
				return on_cols ? pick_between(col_bp[0], col_bp[n - 1])
					: pick_between(row_bp[0], row_bp[n - 1]);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h status %0d", m_tdata, m_tuser);
			end else begin
				want = pending_lookups.pop_front();
				lookups_checked++;
				if (m_tdata !== want.value || m_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %h status %0d, got %h status %0d",
							want.value, want.status, m_tdata, m_tuser);
				end
			end
		end
	end

	initial begin
		int          n;
		int          idx;
		logic [1:0]  act;
		logic [15:0] lo_v;
		logic [15:0] hi_v;
		int          phase_cols [6] = '{16, 2, 0, 9, 1, 31};
		int          phase_rows [6] = '{16, 2, 31, 5, 17, 16};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		lookups_checked = 0;
		requests_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		col_count_reg = 5'd16;
		row_count_reg = 5'd16;
		unity_reg = 1'b0;
		foreach (col_bp[k]) col_bp[k] = '0;
		foreach (row_bp[k]) row_bp[k] = '0;
		foreach (grid_val[k]) grid_val[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_COLUMN_COUNT, 5'd2);
		write_reg(REG_ROW_COUNT, 5'd2);
		write_reg(REG_UNITY_ZERO, 5'd0);
		write_reg(2'd3, 5'd31);

		add_row(0, ACT_COL_BREAK, 0, 0, 16'h1000, 0, 0);
		add_row(0, ACT_COL_BREAK, 0, 1, 16'h3000, 0, 0);
		add_row(0, ACT_ROW_BREAK, 0, 0, 16'h0000, 0, 0);
		add_row(0, ACT_ROW_BREAK, 1, 0, 16'hFFFF, 0, 0);
		add_row(0, ACT_GRID, 0, 0, 16'h0000, 0, 0);
		add_row(0, ACT_GRID, 0, 1, 16'hFFFF, 0, 0);
		add_row(0, ACT_GRID, 1, 0, 16'h4000, 0, 0);
		add_row(0, ACT_GRID, 1, 1, 16'h8000, 0, 0);
		add_row(0, ACT_QUERY, 0, 0, 0, 16'h1000, 16'h0000, 1, '{16'h0000, ST_INSIDE});
		add_row(0, ACT_QUERY, 0, 0, 0, 16'h0000, 16'h0000, 1, '{16'h0000, ST_CLAMPED});
		add_row(0, ACT_QUERY, 0, 0, 0, 16'hFFFF, 16'h0000, 1, '{16'hFFFF, ST_CLAMPED});
		add_row(0, ACT_QUERY, 0, 0, 0, 16'h3000, 16'hFFFF, 1, '{16'h8000, ST_INSIDE});
		add_row(0, ACT_QUERY, 0, 0, 0, 16'h2000, 16'h8000);
		add_row(0, ACT_ROW_BREAK, 1, 0, 16'h0000, 0, 0);
		add_row(0, ACT_QUERY, 0, 0, 0, 16'h2000, 16'h0000);
		add_row(0, ACT_QUERY, 0, 0, 0, 16'hFFFF, 16'h1234, 1, '{16'h8000, ST_CLAMPED});
		add_row(0, ACT_ROW_BREAK, 1, 0, 16'h8000, 0, 0);
		add_row(1, REG_UNITY_ZERO, 0, 0, 1, 0, 0);
		add_row(0, ACT_QUERY, 0, 0, 0, 16'h2000, 16'h0000, 1, '{UNITY_Q14, ST_INSIDE});
		add_row(0, ACT_QUERY, 0, 0, 0, 16'h2000, 16'h0001);
		add_row(1, REG_UNITY_ZERO, 0, 0, 0, 0, 0);
		add_row(0, ACT_COL_BREAK, 0, 15, 16'hFFFF, 0, 0);
		add_row(0, ACT_ROW_BREAK, 15, 0, 16'h0000, 0, 0);
		add_row(0, ACT_GRID, 15, 15, 16'hFFFF, 0, 0);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_cfg) begin
				drain();
				write_reg(directed_rows[k].action, directed_rows[k].wv[4:0]);
			end else begin
				send(directed_rows[k].action, directed_rows[k].ri, directed_rows[k].ci,
					directed_rows[k].wv, directed_rows[k].ck, directed_rows[k].rk,
					directed_rows[k].fixed, directed_rows[k].fixed_exp);
			end
		end

		// Load the whole table with ascending breakpoints before the random part.
		for (int k = 0; k < 16; k++) begin
			send(ACT_COL_BREAK, 4'($urandom), 4'(k), 16'(k * 4096 + $urandom_range(4000)), 0, 0);
			send(ACT_ROW_BREAK, 4'(k), 4'($urandom), 16'(k * 4096 + $urandom_range(4000)), 0, 0);
		end
		for (int k = 0; k < 256; k++)
			send(ACT_GRID, 4'(k / 16), 4'(k % 16), 16'($urandom), 0, 0);

		for (int p = 0; p < 6; p++) begin
			drain();
			write_reg(REG_COLUMN_COUNT, 5'(phase_cols[p]));
			write_reg(REG_ROW_COUNT, 5'(phase_rows[p]));
			write_reg(REG_UNITY_ZERO, 5'(p % 2));
			idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 71 : 9) : 0;
			stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 71 : 9) : 0;
			for (int k = 0; k < 250; k++) begin
				if (p == 2 && k == 125) begin
					s_tvalid <= 1'b0;
					while (pending_lookups.size() != 0) @(posedge clk);
				end
				act = ($urandom_range(99) < 55) ? ACT_QUERY : 2'($urandom_range(2));
				idx = $urandom_range(15);
				case (act)
					ACT_COL_BREAK: begin
						lo_v = (idx > 0) ? col_bp[idx - 1] : 16'h0000;
						hi_v = (idx < 15) ? col_bp[idx + 1] : 16'hFFFF;
						send(act, 4'($urandom), 4'(idx), pick_between(lo_v, hi_v),
							16'($urandom), 16'($urandom));
					end
					ACT_ROW_BREAK: begin
						lo_v = (idx > 0) ? row_bp[idx - 1] : 16'h0000;
						hi_v = (idx < 15) ? row_bp[idx + 1] : 16'hFFFF;
						send(act, 4'(idx), 4'($urandom), pick_between(lo_v, hi_v),
							16'($urandom), 16'($urandom));
					end
					ACT_GRID: begin
						send(act, 4'(idx), 4'($urandom), 16'($urandom),
							16'($urandom), 16'($urandom));
					end
					default: begin
						send(act, 4'($urandom), 4'($urandom), 16'($urandom),
							pick_key(1'b1), pick_key(1'b0));
					end
				endcase
			end
		end

		drain();
		$display("Sent %0d requests over directed, table load and six random phases;",
			requests_sent);
		$display("checked %0d lookups across all count, unity and flow-control settings.",
			lookups_checked);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
